@@ rtl/core/swfr_pkg.sv @@
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants of the stop-and-wait frame receiver core.
// ----------------------------------------------------------------------------
package swfr_pkg;

  // Raw stuffed bytes allowed in one payload before the frame is dropped.
  localparam int unsigned MaxStuffedBytes = 2048;
  localparam int unsigned CountW          = 12;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FLAG_BYTE    = 3'd0,
    CFG_ESCAPE_BYTE  = 3'd1,
    CFG_FLAG_CODE    = 3'd2,
    CFG_ESCAPE_CODE  = 3'd3,
    CFG_ADDRESS_BYTE = 3'd4,
    CFG_CONTROL_SEQ0 = 3'd5,
    CFG_CONTROL_SEQ1 = 3'd6
  } cfg_idx_e;

  // End-of-frame status codes.
  typedef enum logic [2:0] {
    FS_ACCEPTED  = 3'd0,
    FS_DUPLICATE = 3'd1,
    FS_CHECK_ERR = 3'd2,
    FS_ESC_VIOL  = 3'd3,
    FS_OVERFLOW  = 3'd4,
    FS_EMPTY     = 3'd5
  } frame_status_e;

  // Reply codes.
  typedef enum logic [1:0] {
    RK_NONE   = 2'd0,
    RK_RR     = 2'd1,
    RK_REJECT = 2'd2
  } reply_kind_e;

  // Result item kinds.
  typedef enum logic {
    IK_DATA   = 1'b0,
    IK_STATUS = 1'b1
  } item_kind_e;

  // Reset values of the configuration registers.
  localparam logic [7:0] RstFlagByte    = 8'd126;
  localparam logic [7:0] RstEscapeByte  = 8'd125;
  localparam logic [7:0] RstFlagCode    = 8'd94;
  localparam logic [7:0] RstEscapeCode  = 8'd93;
  localparam logic [7:0] RstAddressByte = 8'd3;
  localparam logic [7:0] RstControlSeq0 = 8'd0;
  localparam logic [7:0] RstControlSeq1 = 8'd64;

endpackage

@@ rtl/core/stop_and_wait_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_core
// Hunts for byte-stuffed information frames, destuffs the payload one byte
// late and reports status and reply code at the closing flag or on a fault.
// ----------------------------------------------------------------------------
// Path: a line byte passes the input register, then one pass of frame logic,
// into the output register; a full output holds it in the input register.
// Throughput: one line byte per cycle unless the result channel stalls; the
// input register lets one beat in while a result waits to be taken.
// Reset: configuration returns to its defaults, the receiver hunts for a flag
// and the expected sequence is zero; no clearing pass is needed.
module stop_and_wait_frame_receiver_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Line byte channel.
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   line_byte_i,
  // Result channel.
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         item_kind_o,
  output logic [7:0]                   data_byte_o,
  output logic [2:0]                   frame_status_o,
  output logic [1:0]                   reply_kind_o,
  output logic                         reply_seq_o,
  // Configuration write channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [swfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i
);
  import swfr_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT  = 3'd0,
    ST_FLAG  = 3'd1,
    ST_ADDR  = 3'd2,
    ST_CTRL  = 3'd3,
    ST_DATA0 = 3'd4,
    ST_DATAN = 3'd5
  } hunt_state_e;

  // Configuration registers.
  logic [7:0] flag_byte_q, escape_byte_q, flag_code_q, escape_code_q;
  logic [7:0] address_byte_q, control_seq0_q, control_seq1_q;

  // Input register.
  logic       in_full_q;
  logic [7:0] in_byte_q;

  // Receiver state.
  logic [2:0]        state_q, state_d;
  logic              expected_seq_q, expected_seq_d;
  logic              duplicate_mark_q, duplicate_mark_d;
  logic [7:0]        header_check_q, header_check_d;
  logic              escape_pending_q, escape_pending_d;
  logic [7:0]        held_byte_q, held_byte_d;
  logic              held_valid_q, held_valid_d;
  logic [7:0]        running_check_q, running_check_d;
  logic [CountW-1:0] stuffed_count_q, stuffed_count_d;

  // Result register.
  logic       out_valid_q;
  logic       item_kind_q, item_kind_d;
  logic [7:0] data_byte_q, data_byte_d;
  logic [2:0] frame_status_q, frame_status_d;
  logic [1:0] reply_kind_q, reply_kind_d;
  logic       reply_seq_q, reply_seq_d;
  logic       res_d;

  logic       advance;
  logic [7:0] b, want, other, dest;
  logic       dest_ok;

  // The stored beat moves on when the result slot is free or being emptied.
  assign advance     = in_full_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_full_q || advance;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_byte_q    <= RstFlagByte;
      escape_byte_q  <= RstEscapeByte;
      flag_code_q    <= RstFlagCode;
      escape_code_q  <= RstEscapeCode;
      address_byte_q <= RstAddressByte;
      control_seq0_q <= RstControlSeq0;
      control_seq1_q <= RstControlSeq1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FLAG_BYTE:    flag_byte_q    <= cfg_data_i;
        CFG_ESCAPE_BYTE:  escape_byte_q  <= cfg_data_i;
        CFG_FLAG_CODE:    flag_code_q    <= cfg_data_i;
        CFG_ESCAPE_CODE:  escape_code_q  <= cfg_data_i;
        CFG_ADDRESS_BYTE: address_byte_q <= cfg_data_i;
        CFG_CONTROL_SEQ0: control_seq0_q <= cfg_data_i;
        CFG_CONTROL_SEQ1: control_seq1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= line_byte_i;
    end
  end

  assign b     = in_byte_q;
  assign want  = expected_seq_q ? control_seq1_q : control_seq0_q;
  assign other = expected_seq_q ? control_seq0_q : control_seq1_q;

  // Destuffing of the byte after an escape.
  always_comb begin
    dest_ok = 1'b1;
    if (b == flag_code_q) begin
      dest = flag_byte_q;
    end else if (b == escape_code_q) begin
      dest = escape_byte_q;
    end else begin
      dest    = 8'd0;
      dest_ok = 1'b0;
    end
  end

  // Frame logic for the stored beat.
  always_comb begin
    state_d          = state_q;
    expected_seq_d   = expected_seq_q;
    duplicate_mark_d = duplicate_mark_q;
    header_check_d   = header_check_q;
    escape_pending_d = escape_pending_q;
    held_byte_d      = held_byte_q;
    held_valid_d     = held_valid_q;
    running_check_d  = running_check_q;
    stuffed_count_d  = stuffed_count_q;
    res_d            = 1'b0;
    item_kind_d      = IK_DATA;
    data_byte_d      = 8'd0;
    frame_status_d   = FS_ACCEPTED;
    reply_kind_d     = RK_NONE;
    reply_seq_d      = 1'b0;

    case (state_q)
      ST_FLAG: begin
        if (b == flag_byte_q) state_d = ST_FLAG;
        else if (b == address_byte_q) state_d = ST_ADDR;
        else state_d = ST_HUNT;
      end
      ST_ADDR: begin
        if (b == flag_byte_q) begin
          state_d = ST_FLAG;
        end else if (b == want || b == other) begin
          duplicate_mark_d = (b != want);
          header_check_d   = address_byte_q ^ b;
          state_d          = ST_CTRL;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_CTRL: begin
        if (b == flag_byte_q) begin
          state_d = ST_FLAG;
        end else if (b == header_check_q) begin
          state_d          = ST_DATA0;
          escape_pending_d = 1'b0;
          held_byte_d      = 8'd0;
          held_valid_d     = 1'b0;
          running_check_d  = 8'd0;
          stuffed_count_d  = '0;
        end else begin
          state_d = ST_HUNT;
        end
      end
      ST_DATA0, ST_DATAN: begin
        if (stuffed_count_q >= CountW'(MaxStuffedBytes)) begin
          // Too many raw bytes: drop this one and end the frame.
          res_d          = 1'b1;
          item_kind_d    = IK_STATUS;
          frame_status_d = FS_OVERFLOW;
          state_d        = ST_HUNT;
        end else if (b == flag_byte_q) begin
          // Closing flag.
          res_d       = 1'b1;
          item_kind_d = IK_STATUS;
          state_d     = ST_HUNT;
          if (escape_pending_q) begin
            frame_status_d = FS_ESC_VIOL;
          end else if (state_q == ST_DATA0) begin
            frame_status_d = FS_EMPTY;
          end else if (duplicate_mark_q) begin
            frame_status_d = FS_DUPLICATE;
            reply_kind_d   = RK_RR;
            reply_seq_d    = expected_seq_q;
          end else if (held_byte_q != running_check_q) begin
            frame_status_d = FS_CHECK_ERR;
            reply_kind_d   = RK_REJECT;
            reply_seq_d    = expected_seq_q;
          end else begin
            expected_seq_d = !expected_seq_q;
            frame_status_d = FS_ACCEPTED;
            reply_kind_d   = RK_RR;
            reply_seq_d    = !expected_seq_q;
          end
        end else begin
          stuffed_count_d = stuffed_count_q + CountW'(1);
          if (escape_pending_q && !dest_ok) begin
            // Escape followed by an unknown code.
            escape_pending_d = 1'b0;
            res_d            = 1'b1;
            item_kind_d      = IK_STATUS;
            frame_status_d   = FS_ESC_VIOL;
            state_d          = ST_HUNT;
          end else if (!escape_pending_q && b == escape_byte_q) begin
            escape_pending_d = 1'b1;
          end else begin
            // A payload byte is complete: release the one held before it.
            escape_pending_d = 1'b0;
            if (held_valid_q) begin
              running_check_d = running_check_q ^ held_byte_q;
              res_d           = 1'b1;
              data_byte_d     = held_byte_q;
              state_d         = ST_DATAN;
            end
            held_byte_d  = escape_pending_q ? dest : b;
            held_valid_d = 1'b1;
          end
        end
      end
      default: begin
        if (b == flag_byte_q) state_d = ST_FLAG;
        else state_d = ST_HUNT;
      end
    endcase
  end

  // Receiver state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_HUNT;
      expected_seq_q   <= 1'b0;
      duplicate_mark_q <= 1'b0;
      header_check_q   <= 8'd0;
      escape_pending_q <= 1'b0;
      held_byte_q      <= 8'd0;
      held_valid_q     <= 1'b0;
      running_check_q  <= 8'd0;
      stuffed_count_q  <= '0;
      out_valid_q      <= 1'b0;
    end else begin
      if (advance) begin
        state_q          <= state_d;
        expected_seq_q   <= expected_seq_d;
        duplicate_mark_q <= duplicate_mark_d;
        header_check_q   <= header_check_d;
        escape_pending_q <= escape_pending_d;
        held_byte_q      <= held_byte_d;
        held_valid_q     <= held_valid_d;
        running_check_q  <= running_check_d;
        stuffed_count_q  <= stuffed_count_d;
      end
      if (advance) begin
        out_valid_q <= res_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_d) begin
      item_kind_q    <= item_kind_d;
      data_byte_q    <= data_byte_d;
      frame_status_q <= frame_status_d;
      reply_kind_q   <= reply_kind_d;
      reply_seq_q    <= reply_seq_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign item_kind_o    = item_kind_q;
  assign data_byte_o    = data_byte_q;
  assign frame_status_o = frame_status_q;
  assign reply_kind_o   = reply_kind_q;
  assign reply_seq_o    = reply_seq_q;

  // The raw byte count never passes the overflow limit.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stuffed_count_q <= CountW'(MaxStuffedBytes))
    else $error("stuffed byte count beyond limit");

  // An accepted frame flips the expected sequence bit.
  a_seq_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d && item_kind_d == IK_STATUS && frame_status_d == FS_ACCEPTED)
    |=> (expected_seq_q != $past(expected_seq_q)))
    else $error("accepted frame did not toggle sequence");

  // Any status beat sends the receiver back to the hunt.
  a_status_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d && item_kind_d == IK_STATUS) |=> (state_q == ST_HUNT))
    else $error("receiver not hunting after status");

  // A data beat comes only from a frame in payload with a held byte.
  a_data_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d && item_kind_d == IK_DATA)
    |-> (held_valid_q && (state_q == ST_DATA0 || state_q == ST_DATAN)))
    else $error("data beat outside payload");

endmodule

@@ verif/tb_stop_and_wait_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// tb_stop_and_wait_frame_receiver_core
// Self-checking bench for the frame receiver core. Line bytes are built into
// frames (good, duplicate, bad check, escape faults, empty, broken headers,
// noise, length limit) under several register settings. A scoreboard
// predicts each data beat and end-of-frame status and compares the results
// in order, while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_stop_and_wait_frame_receiver_core;
  timeunit 1ns;
  timeprecision 1ps;

  import swfr_pkg::*;

  localparam int CycleLimit   = 500000;
  localparam int DrainLimit   = 6000;
  localparam int SettleCycles = 8;
  localparam int MaxReported  = 10;

  // Receiver progress through one frame.
  typedef enum logic [2:0] {
    RX_HUNT, RX_FLAG, RX_ADDR, RX_HDR, RX_FIRST, RX_MORE
  } rx_state_e;

  // Kinds of line sequences the stimulus can build.
  typedef enum int {
    FR_GOOD, FR_DUP, FR_BAD_CHECK, FR_ESC_FLAG, FR_ESC_BAD, FR_EMPTY,
    FR_HDR_BROKEN, FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    item_kind_e    kind;
    logic [7:0]    data;
    frame_status_e status;
    reply_kind_e   reply;
    logic          seq;
  } rx_result_t;

  typedef logic [7:0] byte_q_t[$];

  // Predicts data beats and frame status, and checks them in order.
  class frame_scoreboard;
    logic [7:0]        delim, esc_char, delim_code, esc_code;
    logic [7:0]        station_addr, ctrl0, ctrl1;
    rx_state_e         rx_state;
    logic              next_seq, dup_frame, esc_open, held_ok;
    logic [7:0]        hdr_xor, held_data, data_xor;
    logic [CountW-1:0] raw_len;
    rx_result_t        expected_q[$];
    int                failures;

    function new();
      delim        = RstFlagByte;
      esc_char     = RstEscapeByte;
      delim_code   = RstFlagCode;
      esc_code     = RstEscapeCode;
      station_addr = RstAddressByte;
      ctrl0        = RstControlSeq0;
      ctrl1        = RstControlSeq1;
      rx_state     = RX_HUNT;
      next_seq     = 1'b0;
      dup_frame    = 1'b0;
      esc_open     = 1'b0;
      held_ok      = 1'b0;
      hdr_xor      = '0;
      held_data    = '0;
      data_xor     = '0;
      raw_len      = '0;
      failures     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [7:0] v);
      case (idx)
        CFG_FLAG_BYTE:    delim        = v;
        CFG_ESCAPE_BYTE:  esc_char     = v;
        CFG_FLAG_CODE:    delim_code   = v;
        CFG_ESCAPE_CODE:  esc_code     = v;
        CFG_ADDRESS_BYTE: station_addr = v;
        CFG_CONTROL_SEQ0: ctrl0        = v;
        CFG_CONTROL_SEQ1: ctrl1        = v;
        default: ;
      endcase
    endfunction

    // End of frame: queue the status and go back to hunting.
    function void close_frame(frame_status_e st, reply_kind_e rk, logic rs);
      rx_result_t r;
      r.kind   = IK_STATUS;
      r.data   = '0;
      r.status = st;
      r.reply  = rk;
      r.seq    = (rk == RK_NONE) ? 1'b0 : rs;
      expected_q.push_back(r);
      rx_state = RX_HUNT;
    endfunction

    // Advance the prediction by one accepted line beat.
    function void note_line_byte(logic [7:0] b);
      logic [7:0] want, other, d;
      logic       got_d;
      rx_result_t r;
      want  = next_seq ? ctrl1 : ctrl0;
      other = next_seq ? ctrl0 : ctrl1;
      d     = '0;
      got_d = 1'b0;
      case (rx_state)
        RX_FLAG: begin
          if (b == delim) rx_state = RX_FLAG;
          else if (b == station_addr) rx_state = RX_ADDR;
          else rx_state = RX_HUNT;
        end
        RX_ADDR: begin
          if (b == delim) begin
            rx_state = RX_FLAG;
          end else if (b == want || b == other) begin
            // The expected control wins when both registers match.
            dup_frame = (b != want);
            hdr_xor   = station_addr ^ b;
            rx_state  = RX_HDR;
          end else begin
            rx_state = RX_HUNT;
          end
        end
        RX_HDR: begin
          if (b == delim) begin
            rx_state = RX_FLAG;
          end else if (b == hdr_xor) begin
            rx_state  = RX_FIRST;
            esc_open  = 1'b0;
            held_data = '0;
            held_ok   = 1'b0;
            data_xor  = '0;
            raw_len   = '0;
          end else begin
            rx_state = RX_HUNT;
          end
        end
        RX_FIRST, RX_MORE: begin
          if (raw_len >= CountW'(MaxStuffedBytes)) begin
            close_frame(FS_OVERFLOW, RK_NONE, 1'b0);
          end else if (b == delim) begin
            if (esc_open) close_frame(FS_ESC_VIOL, RK_NONE, 1'b0);
            else if (rx_state == RX_FIRST) close_frame(FS_EMPTY, RK_NONE, 1'b0);
            else if (dup_frame) close_frame(FS_DUPLICATE, RK_RR, next_seq);
            else if (held_data != data_xor) close_frame(FS_CHECK_ERR, RK_REJECT, next_seq);
            else begin
              next_seq = ~next_seq;
              close_frame(FS_ACCEPTED, RK_RR, next_seq);
            end
          end else begin
            raw_len = raw_len + CountW'(1);
            if (esc_open) begin
              esc_open = 1'b0;
              if (b == delim_code) begin
                d = delim;
                got_d = 1'b1;
              end else if (b == esc_code) begin
                d = esc_char;
                got_d = 1'b1;
              end else begin
                close_frame(FS_ESC_VIOL, RK_NONE, 1'b0);
              end
            end else if (b == esc_char) begin
              esc_open = 1'b1;
            end else begin
              d = b;
              got_d = 1'b1;
            end
            // Payload leaves one byte late, so the check byte stays held.
            if (got_d) begin
              if (held_ok) begin
                data_xor = data_xor ^ held_data;
                r.kind   = IK_DATA;
                r.data   = held_data;
                r.status = FS_ACCEPTED;
                r.reply  = RK_NONE;
                r.seq    = 1'b0;
                expected_q.push_back(r);
                rx_state = RX_MORE;
              end
              held_data = d;
              held_ok   = 1'b1;
            end
          end
        end
        default: begin
          if (b == delim) rx_state = RX_FLAG;
          else rx_state = RX_HUNT;
        end
      endcase
    endfunction

    function string show(rx_result_t r);
      return $sformatf("kind=%0d data=%02h status=%0d reply=%0d seq=%0d",
                       r.kind, r.data, r.status, r.reply, r.seq);
    endfunction

    // Compare one result beat with the oldest prediction.
    function void check_result(rx_result_t got);
      rx_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MaxReported) $display("unexpected result: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.data !== want.data || got.status !== want.status ||
          got.reply !== want.reply || got.seq !== want.seq) begin
        failures++;
        if (failures <= MaxReported)
          $display("mismatch: expected %s, actual %s", show(want), show(got));
      end
    endfunction

    function void flush_missing();
      while (expected_q.size() > 0) begin
        failures++;
        if (failures <= MaxReported) $display("missing result: %s", show(expected_q[0]));
        void'(expected_q.pop_front());
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [7:0]          line_byte_i = '0;
  logic                out_ready_i = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [7:0]          cfg_data_i  = '0;
  logic                in_ready_o, out_valid_o, cfg_ready_o;
  logic                item_kind_o, reply_seq_o;
  logic [7:0]          data_byte_o;
  logic [2:0]          frame_status_o;
  logic [1:0]          reply_kind_o;

  frame_scoreboard     sb;
  byte_q_t             tx_q;
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  hold_left = 0;
  int                  bytes_sent = 0;
  int                  cycles = 0;

  stop_and_wait_frame_receiver_core u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .line_byte_i,
    .out_valid_o,
    .out_ready_i,
    .item_kind_o,
    .data_byte_o,
    .frame_status_o,
    .reply_kind_o,
    .reply_seq_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("stop_and_wait_frame_receiver_core regression: fail");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick the next ready value.
  always @(posedge clk_i) begin
    rx_result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind   = item_kind_e'(item_kind_o);
      got.data   = data_byte_o;
      got.status = frame_status_e'(frame_status_o);
      got.reply  = reply_kind_e'(reply_kind_o);
      got.seq    = reply_seq_o;
      sb.check_result(got);
    end
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one line beat, idling first at random, and wait for acceptance.
  task automatic send_byte(logic [7:0] b);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    line_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_line_byte(b);
    bytes_sent++;
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
  endtask

  task automatic program_regs(logic [7:0] f, logic [7:0] e, logic [7:0] fc, logic [7:0] ec,
                              logic [7:0] a, logic [7:0] c0, logic [7:0] c1);
    cfg_write(CFG_FLAG_BYTE, f);
    cfg_write(CFG_ESCAPE_BYTE, e);
    cfg_write(CFG_FLAG_CODE, fc);
    cfg_write(CFG_ESCAPE_CODE, ec);
    cfg_write(CFG_ADDRESS_BYTE, a);
    cfg_write(CFG_CONTROL_SEQ0, c0);
    cfg_write(CFG_CONTROL_SEQ1, c1);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering, wait for the predicted results and let the pipe empty.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    sb.flush_missing();
  endtask

  // Payload bytes, biased toward the values that need stuffing.
  function automatic byte_q_t random_payload(int n);
    byte_q_t q;
    int      sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(3);
      if (sel == 0) q.push_back(sb.delim);
      else if (sel == 1) q.push_back(sb.esc_char);
      else q.push_back(8'($urandom_range(255)));
    end
    return q;
  endfunction

  function automatic void stuff_byte(logic [7:0] v);
    if (v == sb.delim) begin
      tx_q.push_back(sb.esc_char);
      tx_q.push_back(sb.delim_code);
    end else if (v == sb.esc_char) begin
      tx_q.push_back(sb.esc_char);
      tx_q.push_back(sb.esc_code);
    end else begin
      tx_q.push_back(v);
    end
  endfunction

  // Build the line beats of one frame. For broken headers the variant picks
  // a restart by flag at address, control or check, or a wrong address,
  // control or header check. For an empty frame it picks whether a lone
  // check byte is sent.
  function automatic void build_frame(frame_kind_e kind, int variant, byte_q_t payload);
    logic [7:0] ctrl, alien, chk, addr;
    logic       broken, esc_fault;
    int         cut;
    if (kind == FR_NOISE) begin
      foreach (payload[i]) tx_q.push_back(payload[i]);
      return;
    end
    broken    = (kind == FR_HDR_BROKEN);
    esc_fault = (kind == FR_ESC_FLAG || kind == FR_ESC_BAD);
    addr      = sb.station_addr;
    ctrl      = (sb.next_seq ^ (kind == FR_DUP)) ? sb.ctrl1 : sb.ctrl0;
    do alien = 8'($urandom_range(255)); while (alien == sb.ctrl0 || alien == sb.ctrl1);

    // Header.
    tx_q.push_back(sb.delim);
    if (broken && variant == 0) tx_q.push_back(sb.delim);
    tx_q.push_back((broken && variant == 3) ? (addr ^ 8'h01) : addr);
    if (broken && variant == 1) begin
      tx_q.push_back(sb.delim);
      tx_q.push_back(addr);
    end
    tx_q.push_back((broken && variant == 4) ? alien : ctrl);
    if (broken && variant == 2) begin
      tx_q.push_back(sb.delim);
      tx_q.push_back(addr);
      tx_q.push_back(ctrl);
    end
    tx_q.push_back((broken && variant == 5) ? (addr ^ ctrl ^ 8'h01) : (addr ^ ctrl));

    // Stuffed payload, with an escape fault at a random place if asked.
    chk = '0;
    foreach (payload[i]) chk = chk ^ payload[i];
    if (kind == FR_BAD_CHECK) chk = chk ^ 8'($urandom_range(1, 255));
    do alien = 8'($urandom_range(255)); while (alien == sb.delim_code || alien == sb.esc_code);
    cut = $urandom_range(payload.size());
    for (int i = 0; i <= payload.size(); i++) begin
      if (esc_fault && i == cut) begin
        tx_q.push_back(sb.esc_char);
        tx_q.push_back((kind == FR_ESC_FLAG) ? sb.delim : alien);
      end
      if (i < payload.size()) stuff_byte(payload[i]);
    end
    if (kind == FR_EMPTY) begin
      if (variant == 1) stuff_byte(8'($urandom_range(255)));
    end else begin
      stuff_byte(chk);
    end
    tx_q.push_back(sb.delim);
  endfunction

  task automatic put_frame(frame_kind_e kind, int variant, byte_q_t payload);
    build_frame(kind, variant, payload);
    while (tx_q.size() > 0) send_byte(tx_q.pop_front());
  endtask

  // Mostly well-formed frames with random content, the rest faults and noise.
  task automatic run_random(int budget);
    int      start, w, len;
    byte_q_t q;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      w   = $urandom_range(99);
      len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      q   = random_payload(len);
      if (w < 45) put_frame(FR_GOOD, 0, q);
      else if (w < 55) put_frame(FR_DUP, 0, q);
      else if (w < 65) put_frame(FR_BAD_CHECK, 0, q);
      else if (w < 70) put_frame(FR_ESC_FLAG, 0, q);
      else if (w < 75) put_frame(FR_ESC_BAD, 0, q);
      else if (w < 80) begin
        q.delete();
        put_frame(FR_EMPTY, $urandom_range(1), q);
      end else if (w < 90) put_frame(FR_HDR_BROKEN, $urandom_range(5), q);
      else put_frame(FR_NOISE, 0, random_payload($urandom_range(1, 6)));
    end
  endtask

  initial begin
    byte_q_t    q;
    logic [7:0] f;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames under the reset settings.
    q = '{8'h00, 8'hFF};
    put_frame(FR_NOISE, 0, q);
    q = '{8'h00, 8'hFF, sb.delim, sb.esc_char, sb.delim_code, sb.esc_code};
    put_frame(FR_GOOD, 0, q);
    put_frame(FR_DUP, 0, q);
    q = '{8'hA5};
    put_frame(FR_GOOD, 0, q);
    put_frame(FR_BAD_CHECK, 0, q);
    put_frame(FR_ESC_FLAG, 0, q);
    put_frame(FR_ESC_BAD, 0, q);
    q.delete();
    put_frame(FR_EMPTY, 0, q);
    put_frame(FR_EMPTY, 1, q);
    q = '{8'h5A, 8'h3C};
    for (int v = 0; v < 6; v++) put_frame(FR_HDR_BROKEN, v, q);
    // Length limit: one raw byte under it closes normally, at it overflows.
    q.delete();
    for (int i = 0; i < MaxStuffedBytes - 2; i++) q.push_back(8'h11);
    put_frame(FR_GOOD, 0, q);
    q.push_back(8'h11);
    put_frame(FR_GOOD, 0, q);
    settle();

    // Reset settings, no idling, with a long receiver hold-off.
    hold_left = 400;
    run_random(90);
    settle();

    // Low flag, high escape; sender mostly idle.
    program_regs(8'h00, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'h01, 8'hFE);
    sender_idle_pct = 87;
    run_random(90);
    settle();

    // High flag, low escape; receiver mostly stalled.
    program_regs(8'hFF, 8'h00, 8'h00, 8'h01, 8'h00, 8'h80, 8'h7F);
    sender_idle_pct    = 0;
    receiver_stall_pct = 87;
    run_random(90);
    settle();

    // Both control bytes equal; both sides idling.
    program_regs(8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h80, 8'h55, 8'h55);
    sender_idle_pct    = 31;
    receiver_stall_pct = 31;
    run_random(90);
    settle();

    // Random settings, no idling, another hold-off.
    f = 8'($urandom_range(255));
    program_regs(f, f ^ 8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_left          = 300;
    run_random(90);
    settle();

    // Back to the reset values with both sides idling.
    program_regs(RstFlagByte, RstEscapeByte, RstFlagCode, RstEscapeCode,
                 RstAddressByte, RstControlSeq0, RstControlSeq1);
    sender_idle_pct    = 31;
    receiver_stall_pct = 31;
    run_random(90);
    settle();

    if (sb.failures == 0) begin
      $display("stop_and_wait_frame_receiver_core regression: pass");
    end else begin
      $display("stop_and_wait_frame_receiver_core regression: fail");
    end
    $finish;
  end

endmodule
